// File: rtl/assert_macros.svh
// Assertion macros used by the system port register block.
// Each macro expects clk_i and rst_ni to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPRB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/sprb_pkg.sv
package sprb_pkg;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } sprb_op_e;

  localparam logic [8:0] ADDR_CALENDAR   = 9'h010;
  localparam logic [8:0] ADDR_SOUND_MASK = 9'h032;
  localparam logic [8:0] ADDR_CONTROL    = 9'h040;
  localparam logic [8:0] ADDR_MODE_LO    = 9'h150;
  localparam logic [8:0] ADDR_MODE_HI    = 9'h151;
  localparam logic [8:0] ADDR_MODE_SET   = 9'h1C6;
  localparam logic [8:0] ADDR_PORT_A     = 9'h1C9;
  localparam logic [8:0] ADDR_PORT_C     = 9'h1CD;
  localparam logic [8:0] ADDR_PORT_C_BSR = 9'h1CF;

  localparam logic [7:0]  RESET_PORT_C     = 8'hF9;
  localparam logic [7:0]  RESET_PORT_A     = 8'hC1;
  localparam logic [15:0] MODE_SWITCH_A    = 16'hFFFE;
  localparam logic [15:0] MODE_SWITCH_B    = 16'hFFFD;
  localparam logic [7:0]  SOUND_MASK_KEEP  = 8'hBF;
  localparam logic [7:0]  STATUS_BASE      = 8'hC1;
  localparam logic [7:0]  UNMAPPED_READ    = 8'hFF;
  localparam logic [2:0]  LED_ALL_OFF_CODE = 3'h7;
  localparam logic [3:0]  BSR_HIGH_NIBBLE  = 4'h0;
  localparam logic [2:0]  PORT_C_SERIAL_BIT = 3'd2;
  localparam logic [2:0]  PORT_C_BEEP_BIT   = 3'd3;

  typedef struct packed {
    sprb_op_e    op;
    logic [8:0]  port_address;
    logic [7:0]  write_data;
    logic        vsync_flag;
    logic        calendar_data_in;
  } sprb_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] led_on;
    logic [5:0] calendar_lines;
    logic       calendar_update;
    logic       serial_send;
    logic       beep_update;
    logic [7:0] port_c_value;
  } sprb_rsp_t;

endpackage

// File: rtl/sprb_in_stage.sv
module sprb_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sprb_pkg::sprb_req_t req_i,
  input  logic                advance_i,
  output logic                valid_o,
  output sprb_pkg::sprb_req_t req_o
);
  import sprb_pkg::*;

  logic      valid_q, valid_d;
  logic      load;
  sprb_req_t req_q;

  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

// File: rtl/sprb_ports.sv
module sprb_ports (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  sprb_pkg::sprb_req_t req_i,
  output sprb_pkg::sprb_rsp_t rsp_o
);
  import sprb_pkg::*;

  logic [7:0]  calendar_q, calendar_d;
  logic [7:0]  control_q, control_d;
  logic [7:0]  sound_mask_q, sound_mask_d;
  logic [7:0]  port_c_q, port_c_d;
  logic [7:0]  port_a_q, port_a_d;
  logic [15:0] mode_q, mode_d;
  logic [2:0]  bit_pos;
  logic [2:0]  led_code;

  assign bit_pos = req_i.write_data[3:1];

  always_comb begin
    calendar_d   = calendar_q;
    control_d    = control_q;
    sound_mask_d = sound_mask_q;
    port_c_d     = port_c_q;
    port_a_d     = port_a_q;
    mode_d       = mode_q;
    rsp_o        = '0;

    if (req_i.op == OP_READ) begin
      case (req_i.port_address)
        ADDR_SOUND_MASK: rsp_o.read_data = sound_mask_q;
        ADDR_CONTROL: begin
          rsp_o.read_data = STATUS_BASE | {2'b00, req_i.vsync_flag,
                                           req_i.calendar_data_in, 4'h0};
        end
        ADDR_MODE_LO: rsp_o.read_data = mode_q[7:0];
        ADDR_MODE_HI: rsp_o.read_data = mode_q[15:8];
        ADDR_PORT_A:  rsp_o.read_data = port_a_q;
        ADDR_PORT_C:  rsp_o.read_data = port_c_q;
        default:      rsp_o.read_data = UNMAPPED_READ;
      endcase
    end else begin
      case (req_i.port_address)
        ADDR_CALENDAR: begin
          calendar_d            = req_i.write_data;
          rsp_o.calendar_update = 1'b1;
        end
        ADDR_SOUND_MASK: sound_mask_d = req_i.write_data & SOUND_MASK_KEEP;
        ADDR_CONTROL: begin
          control_d             = req_i.write_data;
          rsp_o.calendar_update = 1'b1;
        end
        ADDR_MODE_SET: begin
          mode_d      = req_i.write_data[0] ? MODE_SWITCH_A : MODE_SWITCH_B;
          port_a_d[5] = req_i.write_data[1];
        end
        ADDR_PORT_C: begin
          rsp_o.serial_send = port_c_q[2] ^ req_i.write_data[2];
          rsp_o.beep_update = 1'b1;
          port_c_d          = req_i.write_data;
        end
        ADDR_PORT_C_BSR: begin
          if (req_i.write_data[7:4] == BSR_HIGH_NIBBLE) begin
            port_c_d[bit_pos] = req_i.write_data[0];
            rsp_o.serial_send = (bit_pos == PORT_C_SERIAL_BIT);
            rsp_o.beep_update = (bit_pos == PORT_C_BEEP_BIT);
          end
        end
        default: ;
      endcase
    end

    led_code = port_c_d[6:4];
    if (led_code == LED_ALL_OFF_CODE) begin
      led_code = 3'h0;
    end
    rsp_o.led_on         = ~led_code;
    rsp_o.calendar_lines = {calendar_d[3], control_d[2:1], calendar_d[2:0]};
    rsp_o.port_c_value   = port_c_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calendar_q   <= 8'h00;
      control_q    <= 8'h00;
      sound_mask_q <= 8'h00;
      port_c_q     <= RESET_PORT_C;
      port_a_q     <= RESET_PORT_A;
      mode_q       <= MODE_SWITCH_B;
    end else if (fire_i) begin
      calendar_q   <= calendar_d;
      control_q    <= control_d;
      sound_mask_q <= sound_mask_d;
      port_c_q     <= port_c_d;
      port_a_q     <= port_a_d;
      mode_q       <= mode_d;
    end
  end

endmodule

// File: rtl/sprb_out_stage.sv
module sprb_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  sprb_pkg::sprb_rsp_t rsp_i,
  output logic                advance_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sprb_pkg::sprb_rsp_t rsp_o
);
  import sprb_pkg::*;

  logic      valid_q, valid_d;
  sprb_rsp_t rsp_q;

  assign advance_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (fire_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      rsp_q <= rsp_i;
    end
  end

  assign out_valid_o = valid_q;
  assign rsp_o       = rsp_q;

endmodule

// File: rtl/system_port_register_block.sv
// System I/O port register block.
// The input channel carries one bus access per transfer: op, port address,
// write byte and the live vsync and calendar data-in bits. The output
// channel returns one result per access: read byte (zero on writes), LED
// lines decoded from port C, the composed calendar chip lines with their
// update strobe, the serial-send and beep-update pulses, and port C.
// An accepted access is held in the input register, decoded against the
// port registers, and its result is written to the output register, from
// which it is offered to the receiver.
// One access is taken every cycle unless the receiver stalls. Register
// updates are one combinational pass between input and output registers.
// Reset clears the valid flags of both pipeline registers and loads the port
// registers with their power-on values (port C 0xF9, port A 0xC1, mode switch
// 0xFFFD, the latches and the sound mask zero).
// While the receiver stalls, the result register holds its contents; one
// more access can sit in the input register, after which in_stall_o rises.
module system_port_register_block (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       op_i,
  input  logic [8:0] port_address_i,
  input  logic [7:0] write_data_i,
  input  logic       vsync_flag_i,
  input  logic       calendar_data_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic [2:0] led_on_o,
  output logic [5:0] calendar_lines_o,
  output logic       calendar_update_o,
  output logic       serial_send_o,
  output logic       beep_update_o,
  output logic [7:0] port_c_value_o
);
  import sprb_pkg::*;

  `include "assert_macros.svh"

  sprb_req_t req_in, req_q;
  sprb_rsp_t rsp_d, rsp_q;
  logic      stage_valid;
  logic      advance;
  logic      fire;

  assign req_in.op               = sprb_op_e'(op_i);
  assign req_in.port_address     = port_address_i;
  assign req_in.write_data       = write_data_i;
  assign req_in.vsync_flag       = vsync_flag_i;
  assign req_in.calendar_data_in = calendar_data_in_i;

  assign fire = stage_valid && advance;

  sprb_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_i      (req_in),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .req_o      (req_q)
  );

  sprb_ports u_ports (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (req_q),
    .rsp_o  (rsp_d)
  );

  sprb_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .rsp_i       (rsp_d),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rsp_o       (rsp_q)
  );

  assign read_data_o       = rsp_q.read_data;
  assign led_on_o          = rsp_q.led_on;
  assign calendar_lines_o  = rsp_q.calendar_lines;
  assign calendar_update_o = rsp_q.calendar_update;
  assign serial_send_o     = rsp_q.serial_send;
  assign beep_update_o     = rsp_q.beep_update;
  assign port_c_value_o    = rsp_q.port_c_value;

  `SPRB_ASSERT_NEXT(a_accept_fills_stage, in_valid_i && !in_stall_o, stage_valid)
  `SPRB_ASSERT_SAME(a_stall_only_when_full, in_stall_o, out_valid_o && out_stall_i)
  `SPRB_ASSERT_SAME(a_led_never_dark, out_valid_o, led_on_o != 3'h0)
  `SPRB_ASSERT_SAME(a_write_reads_zero, out_valid_o && calendar_update_o, read_data_o == 8'h00 && !serial_send_o && !beep_update_o)

endmodule
